>>> rtl/ufss_pkg.sv
`timescale 1ns / 1ps
package ufss_pkg;

   // Table geometry
   localparam int NUM_ELEMENTS = 65536;
   localparam int IDX_W        = $clog2(NUM_ELEMENTS);
   localparam int CNT_W        = $clog2(NUM_ELEMENTS + 1);

   // Field widths of the request and response
   localparam int ELEM_W = 16;
   localparam int SIZE_W = 17;
   localparam int RANK_W = 5;

   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   // Operation codes
   localparam logic OP_LINK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [RANK_W-1:0] rank_type;

   // One table word: parent link, and rank and size that count at a root
   typedef struct packed {
      idx_type  parent;
      rank_type rank;
      size_type size;
   } entry_type;

   // Port request from the controller to the table store
   typedef struct packed {
      logic      rd_en;
      idx_type   rd_addr;
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
   } mem_req_type;

   typedef struct packed {
      size_type set_size;
      logic     same_set;
   } result_type;

   // Saturate an element index to the last table entry
   function automatic idx_type clamp_index(elem_type v);
      idx_type r;
      if (32'(v) >= 32'(NUM_ELEMENTS)) begin
         r = idx_type'(NUM_ELEMENTS - 1);
      end else begin
         r = idx_type'(v);
      end
      return r;
   endfunction

endpackage

>>> rtl/ufss_ifs.sv
`timescale 1ns / 1ps
interface ufss_req_if;
   import ufss_pkg::*;

   logic     valid;
   logic     ready;
   logic     operation;
   elem_type first_element;
   elem_type second_element;

   modport source (output valid, output operation, output first_element,
                   output second_element, input ready);
   modport sink   (input valid, input operation, input first_element,
                   input second_element, output ready);
endinterface

interface ufss_rsp_if;
   import ufss_pkg::*;

   logic     valid;
   logic     ready;
   size_type set_size;
   logic     same_set;

   modport source (output valid, output set_size, output same_set, input ready);
   modport sink   (input valid, input set_size, input same_set, output ready);
endinterface

>>> rtl/ufss_store.sv
`timescale 1ns / 1ps
module ufss_store (
   input  logic                  clock,
   input  logic                  reset,
   input  ufss_pkg::mem_req_type mem_req,
   output ufss_pkg::entry_type   rd_data,
   output logic                  clear_done
);
   import ufss_pkg::*;

   entry_type            mem [NUM_ELEMENTS];
   entry_type            rd_data_ff;
   logic [CNT_W-1:0]     clr_cnt_ff;
   logic [CNT_W-1:0]     clr_cnt_in;
   logic                 clr_done_ff;
   logic                 clr_done_in;
   logic                 wr_en;
   idx_type              wr_addr;
   entry_type            wr_data;

   // Sweep the table once after reset, one entry a cycle
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_in == CNT_W'(NUM_ELEMENTS)) begin
            clr_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_done_ff <= clr_done_in;
      end
   end

   // Give the write port to the sweep until it has finished
   always_comb begin
      if (!clr_done_ff) begin
         wr_en          = 1'b1;
         wr_addr        = clr_cnt_ff[IDX_W-1:0];
         wr_data.parent = clr_cnt_ff[IDX_W-1:0];
         wr_data.rank   = '0;
         wr_data.size   = size_type'(1);
      end else begin
         wr_en   = mem_req.wr_en;
         wr_addr = mem_req.wr_addr;
         wr_data = mem_req.wr_data;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = clr_done_ff;

endmodule

>>> rtl/ufss_ctrl.sv
`timescale 1ns / 1ps
module ufss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   ufss_req_if.sink              req_if,
   input  logic                  clear_done,
   output ufss_pkg::mem_req_type mem_req,
   input  ufss_pkg::entry_type   rd_data,
   output logic                  res_valid,
   input  logic                  res_ready,
   output ufss_pkg::result_type  res
);
   import ufss_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE        = 8'b0000_0001,
      S_FIND_ISSUE  = 8'b0000_0010,
      S_FIND        = 8'b0000_0100,
      S_COMP        = 8'b0000_1000,
      S_DECIDE      = 8'b0001_0000,
      S_LINK_LOSER  = 8'b0010_0000,
      S_LINK_WINNER = 8'b0100_0000,
      S_RESULT      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      op_ff, op_in;
   idx_type   elem_a_ff, elem_a_in;
   idx_type   elem_b_ff, elem_b_in;
   logic      side_ff, side_in;
   idx_type   cur_ff, cur_in;
   idx_type   root_a_ff, root_a_in;
   idx_type   root_b_ff, root_b_in;
   rank_type  rank_a_ff, rank_a_in;
   rank_type  rank_b_ff, rank_b_in;
   size_type  size_a_ff, size_a_in;
   size_type  size_b_ff, size_b_in;
   logic      same_ff, same_in;
   logic      win_a_ff, win_a_in;
   size_type  sum_ff, sum_in;
   size_type  set_size_ff, set_size_in;

   logic              accept;
   logic              phase_done;
   idx_type           start;
   idx_type           root_cur;
   logic [SIZE_W:0]   sum_wide;
   rank_type          win_rank;

   assign req_if.ready = (state_ff == S_IDLE) && clear_done;
   assign accept       = req_if.valid && req_if.ready;

   assign start    = side_ff ? elem_b_ff : elem_a_ff;
   assign root_cur = side_ff ? root_b_ff : root_a_ff;
   assign sum_wide = {1'b0, size_a_ff} + {1'b0, size_b_ff};

   // Rank of the winning root: the second root grows on a tie
   always_comb begin
      if (win_a_ff) begin
         win_rank = rank_a_ff;
      end else if (rank_a_ff == rank_b_ff && rank_b_ff != RANK_MAX) begin
         win_rank = rank_b_ff + 1'b1;
      end else begin
         win_rank = rank_b_ff;
      end
   end

   // Walk, compress and link
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      elem_a_in   = elem_a_ff;
      elem_b_in   = elem_b_ff;
      side_in     = side_ff;
      cur_in      = cur_ff;
      root_a_in   = root_a_ff;
      root_b_in   = root_b_ff;
      rank_a_in   = rank_a_ff;
      rank_b_in   = rank_b_ff;
      size_a_in   = size_a_ff;
      size_b_in   = size_b_ff;
      same_in     = same_ff;
      win_a_in    = win_a_ff;
      sum_in      = sum_ff;
      set_size_in = set_size_ff;
      mem_req     = '0;
      phase_done  = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_if.operation;
               elem_a_in = clamp_index(req_if.first_element);
               elem_b_in = clamp_index(req_if.second_element);
               side_in   = 1'b0;
               state_in  = S_FIND_ISSUE;
            end
         end
         S_FIND_ISSUE: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = start;
            cur_in          = start;
            state_in        = S_FIND;
         end
         S_FIND: begin
            if (rd_data.parent == cur_ff) begin
               // root reached: hold its rank and size
               if (side_ff) begin
                  root_b_in = cur_ff;
                  rank_b_in = rd_data.rank;
                  size_b_in = rd_data.size;
               end else begin
                  root_a_in = cur_ff;
                  rank_a_in = rd_data.rank;
                  size_a_in = rd_data.size;
               end
               if (start == cur_ff) begin
                  phase_done = 1'b1;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = start;
                  cur_in          = start;
                  state_in        = S_COMP;
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_data.parent;
               cur_in          = rd_data.parent;
            end
         end
         S_COMP: begin
            // point this node straight at the root, then advance
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = cur_ff;
            mem_req.wr_data.parent = root_cur;
            mem_req.wr_data.rank   = rd_data.rank;
            mem_req.wr_data.size   = rd_data.size;
            if (rd_data.parent == root_cur) begin
               phase_done = 1'b1;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_data.parent;
               cur_in          = rd_data.parent;
            end
         end
         S_DECIDE: begin
            same_in     = (root_a_ff == root_b_ff);
            win_a_in    = (rank_a_ff > rank_b_ff);
            set_size_in = size_a_ff;
            sum_in      = sum_wide[SIZE_W] ? SIZE_MAX : sum_wide[SIZE_W-1:0];
            if (op_ff == OP_QUERY || root_a_ff == root_b_ff) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_LINK_LOSER;
            end
         end
         S_LINK_LOSER: begin
            mem_req.wr_en = 1'b1;
            if (win_a_ff) begin
               mem_req.wr_addr        = root_b_ff;
               mem_req.wr_data.parent = root_a_ff;
               mem_req.wr_data.rank   = rank_b_ff;
               mem_req.wr_data.size   = size_b_ff;
            end else begin
               mem_req.wr_addr        = root_a_ff;
               mem_req.wr_data.parent = root_b_ff;
               mem_req.wr_data.rank   = rank_a_ff;
               mem_req.wr_data.size   = size_a_ff;
            end
            state_in = S_LINK_WINNER;
         end
         S_LINK_WINNER: begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = win_a_ff ? root_a_ff : root_b_ff;
            mem_req.wr_data.parent = win_a_ff ? root_a_ff : root_b_ff;
            mem_req.wr_data.rank   = win_rank;
            mem_req.wr_data.size   = sum_ff;
            set_size_in            = sum_ff;
            state_in               = S_RESULT;
         end
         S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Move on to the second element, or to the link decision
      if (phase_done) begin
         if (!side_ff) begin
            side_in  = 1'b1;
            state_in = S_FIND_ISSUE;
         end else begin
            state_in = S_DECIDE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      elem_a_ff   <= elem_a_in;
      elem_b_ff   <= elem_b_in;
      side_ff     <= side_in;
      cur_ff      <= cur_in;
      root_a_ff   <= root_a_in;
      root_b_ff   <= root_b_in;
      rank_a_ff   <= rank_a_in;
      rank_b_ff   <= rank_b_in;
      size_a_ff   <= size_a_in;
      size_b_ff   <= size_b_in;
      same_ff     <= same_in;
      win_a_ff    <= win_a_in;
      sum_ff      <= sum_in;
      set_size_ff <= set_size_in;
   end

   assign res.set_size = set_size_ff;
   assign res.same_set = same_ff;

   // No same-cycle read and write of one entry
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
      else $error("read and write of the same entry in one cycle");

   // A link only ever joins two distinct roots
   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK_LOSER |-> root_a_ff != root_b_ff)
      else $error("link of a root with itself");

   // No request is taken before the clearing sweep has finished
   a_accept_cleared: assert property (@(posedge clock) disable iff (reset)
      accept |-> clear_done)
      else $error("request accepted during clearing sweep");

   // A set never reports size zero
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res.set_size != '0)
      else $error("zero set size");

   // The loser write is always followed by the winner write
   a_link_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LINK_LOSER |=> state_ff == S_LINK_WINNER && mem_req.wr_en)
      else $error("link left half done");

endmodule

>>> rtl/union_find_set_size.sv
`timescale 1ns / 1ps
// Disjoint-set engine with union by rank, path compression and set sizes.
// req_if carries one request: operation (link or query) and two element
// indexes; indexes past the table are saturated to the last element.
// rsp_if returns exactly one response per request: set_size and same_set.
// Handshake on both channels: a transfer at a rising edge with valid and
// ready high.
// Each element is resolved by a root walk and then a compression pass
// that points every node on its path at the root, both through the single
// read port of the table memory. A link that joins two sets adds the
// S_LINK_LOSER and S_LINK_WINNER writes after the S_DECIDE state.
// The next request is taken once the current response sits in the output
// register, so requests are processed one at a time.
// Reset (synchronous) starts a clearing pass over all NUM_ELEMENTS entries
// (65536) that sets every element to its own root of rank 0 and size 1;
// req_if.ready stays low until it ends.
// When the receiver stalls, the response waits in the output register and
// the next request is processed; its response then holds until the
// register frees.
module union_find_set_size (
   input  logic        clock,
   input  logic        reset,
   ufss_req_if.sink    req_if,
   ufss_rsp_if.source  rsp_if
);
   import ufss_pkg::*;

   mem_req_type mem_req;
   entry_type   rd_data;
   logic        clear_done;
   logic        res_valid;
   logic        res_ready;
   result_type  res;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   ufss_store u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .clear_done (clear_done)
   );

   ufss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .clear_done (clear_done),
      .mem_req    (mem_req),
      .rd_data    (rd_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.set_size = rsp_data_ff.set_size;
   assign rsp_if.same_set = rsp_data_ff.same_set;

endmodule
